[hdl/fda_pkg.sv]
package fda_pkg;

  localparam int unsigned BURST_MAX = 7;
  localparam int unsigned BURST_CW  = $clog2(BURST_MAX + 1);

  localparam logic [7:0] TAG_AUDIO   = 8'd8;
  localparam logic [7:0] TAG_VIDEO   = 8'd9;
  localparam logic [3:0] CODEC_AVC   = 4'd7;
  localparam logic [3:0] CODEC_AAC   = 4'd10;
  localparam logic [4:0] AOT_ESCAPE  = 5'd31;

  localparam logic [7:0] ADTS_SYNC0  = 8'hFF;
  localparam logic [7:0] ADTS_SYNC1  = 8'hF1;
  localparam logic [7:0] ADTS_FULL_LO = 8'hFC;
  localparam logic [4:0] ADTS_FULL_HI = 5'h1F;

  localparam logic STREAM_VIDEO = 1'b0;
  localparam logic STREAM_AUDIO = 1'b1;

endpackage

[hdl/flv_demux_annexb_adts.sv]
// Channel  | dir | tdata            | tuser      | tlast
// s_axis   | in  | [7:0] in_byte    | -          | -
// m_axis   | out | [7:0] out_byte   | out_stream | out_last
//
// Each accepted byte updates the parser state in the same cycle and loads
// its results (0, 1, 4 or 7 bytes) into a burst register on the output side.
// Rate: one byte per cycle while each byte gives at most one result and the
// output is ready; a byte that gives n results holds the input until its burst has drained.
// s_axis_tready_o rises again in the cycle the last burst beat leaves.
// Reset (rst_ni low, async) returns the parser to the file signature.
module flv_demux_annexb_adts (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] in_byte
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] out_byte
  output logic       m_axis_tuser_o,   // [0] out_stream
  output logic       m_axis_tlast_o
);
  import fda_pkg::*;

  typedef enum logic [4:0] {
    PH_SIG, PH_HLEN, PH_HEXT, PH_PREV, PH_THDR, PH_SKIP,
    PH_VFIRST, PH_VPTYPE, PH_VCTIME, PH_CFG,
    PH_SPSNUM, PH_SPSLEN, PH_SPSDATA, PH_PPSNUM, PH_PPSLEN, PH_PPSDATA,
    PH_NALLEN, PH_NALDATA, PH_AFIRST, PH_APTYPE,
    PH_ASC0, PH_ASCEXT, PH_ASC1, PH_RAW
  } phase_e;

  phase_e       phase_q, phase_d;
  logic [31:0]  pcount_q, pcount_d;
  logic [31:0]  hlen_q, hlen_d;
  logic [7:0]   kind_q, kind_d;
  logic [23:0]  trem_q, trem_d;
  logic [2:0]   nsb_q, nsb_d;
  logic [31:0]  ulen_q, ulen_d;
  logic [4:0]   sets_q, sets_d;
  logic [1:0]   prof_q, prof_d;
  logic [3:0]   rate_q, rate_d;
  logic [2:0]   chan_q, chan_d;

  logic [7:0]          burst_q [BURST_MAX];
  logic [7:0]          burst_d [BURST_MAX];
  logic [BURST_CW-1:0] cnt_q, bn;
  logic                strm_q, bs;

  logic accept, take;
  logic [7:0] b;

  assign b               = s_axis_tdata_i;
  assign s_axis_tready_o = (cnt_q == '0) || (cnt_q == BURST_CW'(1) && m_axis_tready_i);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = (cnt_q != '0);
  assign take            = m_axis_tvalid_o && m_axis_tready_i;
  assign m_axis_tdata_o  = burst_q[0];
  assign m_axis_tuser_o  = strm_q;
  assign m_axis_tlast_o  = (cnt_q == BURST_CW'(1));

  always_comb begin
    logic        set_done, is_pps, start, single;
    logic [4:0]  aot;
    logic [12:0] flen;
    phase_d = phase_q; pcount_d = pcount_q; hlen_d = hlen_q; kind_d = kind_q;
    trem_d = trem_q; nsb_d = nsb_q; ulen_d = ulen_q; sets_d = sets_q;
    prof_d = prof_q; rate_d = rate_q; chan_d = chan_q;
    set_done = 1'b0; is_pps = 1'b0; start = 1'b0; single = 1'b0;
    bn = '0; bs = STREAM_VIDEO;
    aot = b[7:3];
    for (int i = 0; i < BURST_MAX; i++) burst_d[i] = 8'h00;
    flen = 13'd0;

    case (phase_q)
      PH_SIG: begin
        pcount_d = pcount_q + 32'd1;
        if (pcount_d >= 32'd5) begin
          pcount_d = '0; hlen_d = '0; phase_d = PH_HLEN;
        end
      end
      PH_HLEN: begin
        hlen_d   = {hlen_q[23:0], b};
        pcount_d = pcount_q + 32'd1;
        if (pcount_d >= 32'd4) begin
          if (hlen_d > 32'd9) begin
            pcount_d = 32'd9; phase_d = PH_HEXT;
          end else begin
            pcount_d = '0; phase_d = PH_PREV;
          end
        end
      end
      PH_HEXT: begin
        pcount_d = pcount_q + 32'd1;
        if (pcount_d >= hlen_q) begin
          pcount_d = '0; phase_d = PH_PREV;
        end
      end
      PH_PREV: begin
        pcount_d = pcount_q + 32'd1;
        if (pcount_d >= 32'd4) begin
          pcount_d = '0; trem_d = '0; phase_d = PH_THDR;
        end
      end
      PH_THDR: begin
        if (pcount_q == '0) kind_d = b;
        else if (pcount_q <= 32'd3) trem_d = {trem_q[15:0], b};
        pcount_d = pcount_q + 32'd1;
        if (pcount_d >= 32'd11) begin
          pcount_d = '0; ulen_d = '0;
          if (trem_d == '0)           phase_d = PH_PREV;
          else if (kind_d == TAG_VIDEO) phase_d = PH_VFIRST;
          else if (kind_d == TAG_AUDIO) phase_d = PH_AFIRST;
          else                        phase_d = PH_SKIP;
        end
      end
      default: begin
        // tag data byte
        trem_d = trem_q - 24'd1;
        case (phase_q)
          PH_VFIRST: phase_d = (b[3:0] == CODEC_AVC) ? PH_VPTYPE : PH_SKIP;
          PH_VPTYPE: begin
            ulen_d = {24'd0, b}; pcount_d = '0; phase_d = PH_VCTIME;
          end
          PH_VCTIME: begin
            pcount_d = pcount_q + 32'd1;
            if (pcount_d >= 32'd3) begin
              pcount_d = '0;
              if (ulen_q == '0)          phase_d = PH_CFG;
              else if (ulen_q == 32'd1)  phase_d = PH_NALLEN;
              else                       phase_d = PH_SKIP;
              ulen_d = '0;
            end
          end
          PH_CFG: begin
            if (pcount_q == 32'd4) begin
              nsb_d = {1'b0, b[1:0]} + 3'd1; phase_d = PH_SPSNUM;
            end
            pcount_d = pcount_q + 32'd1;
          end
          PH_SPSNUM, PH_PPSNUM: begin
            sets_d = b[4:0]; pcount_d = '0; ulen_d = '0;
            if (phase_q == PH_SPSNUM)
              phase_d = (b[4:0] == '0) ? PH_PPSNUM : PH_SPSLEN;
            else
              phase_d = (b[4:0] == '0) ? PH_SKIP : PH_PPSLEN;
          end
          PH_SPSLEN, PH_PPSLEN: begin
            is_pps   = (phase_q == PH_PPSLEN);
            ulen_d   = {16'd0, ulen_q[7:0], b};
            pcount_d = pcount_q + 32'd1;
            if (pcount_d >= 32'd2) begin
              start = 1'b1; pcount_d = '0;
              if (ulen_d == '0) set_done = 1'b1;
              else phase_d = is_pps ? PH_PPSDATA : PH_SPSDATA;
            end
          end
          PH_SPSDATA, PH_PPSDATA: begin
            is_pps = (phase_q == PH_PPSDATA);
            single = 1'b1;
            ulen_d = ulen_q - 32'd1;
            if (ulen_d == '0) set_done = 1'b1;
          end
          PH_NALLEN: begin
            ulen_d   = {ulen_q[23:0], b};
            pcount_d = pcount_q + 32'd1;
            if (pcount_d >= {29'd0, nsb_q}) begin
              start = 1'b1; pcount_d = '0;
              if (ulen_d != '0) phase_d = PH_NALDATA;
            end
          end
          PH_NALDATA: begin
            single = 1'b1;
            ulen_d = ulen_q - 32'd1;
            if (ulen_d == '0) begin
              phase_d = PH_NALLEN; pcount_d = '0;
            end
          end
          PH_AFIRST: phase_d = (b[7:4] == CODEC_AAC) ? PH_APTYPE : PH_SKIP;
          PH_APTYPE: begin
            if (b == 8'd0) phase_d = PH_ASC0;
            else if (b == 8'd1) begin
              // ADTS header, length counts the 7 header bytes plus the raw bytes still in the tag
              flen = 13'd7 + trem_d[12:0];
              bn = BURST_CW'(7); bs = STREAM_AUDIO;
              burst_d[0] = ADTS_SYNC0;
              burst_d[1] = ADTS_SYNC1;
              burst_d[2] = {prof_q, rate_q, 1'b0, chan_q[2]};
              burst_d[3] = {chan_q[1:0], 4'b0000, flen[12:11]};
              burst_d[4] = flen[10:3];
              burst_d[5] = {flen[2:0], ADTS_FULL_HI};
              burst_d[6] = ADTS_FULL_LO;
              phase_d = PH_RAW;
            end else phase_d = PH_SKIP;
          end
          PH_ASC0: begin
            if (aot >= 5'd1 && aot <= 5'd3) prof_d = aot[1:0] - 2'd1;
            ulen_d  = {29'd0, b[2:0]};
            phase_d = (aot == AOT_ESCAPE) ? PH_ASCEXT : PH_ASC1;
          end
          PH_ASCEXT: begin
            ulen_d = {29'd0, b[2:0]}; phase_d = PH_ASC1;
          end
          PH_ASC1: begin
            rate_d = {ulen_q[2:0], b[7]};
            chan_d = b[5:3];
            ulen_d = '0; phase_d = PH_SKIP;
          end
          PH_RAW: begin
            single = 1'b1;
          end
          default: ;
        endcase

        if (set_done) begin
          sets_d = sets_q - 5'd1; ulen_d = '0; pcount_d = '0;
          if (sets_d == '0) phase_d = is_pps ? PH_SKIP : PH_PPSNUM;
          else              phase_d = is_pps ? PH_PPSLEN : PH_SPSLEN;
        end
        if (start) begin
          bn = BURST_CW'(4); bs = STREAM_VIDEO;
          burst_d[3] = 8'h01;
        end
        if (single) begin
          bn = BURST_CW'(1);
          bs = (phase_q == PH_RAW) ? STREAM_AUDIO : STREAM_VIDEO;
          burst_d[0] = b;
        end
        if (trem_d == '0) begin
          phase_d = PH_PREV; pcount_d = '0; ulen_d = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SIG; pcount_q <= '0; hlen_q <= '0; kind_q <= '0;
      trem_q <= '0; nsb_q <= 3'd4; ulen_q <= '0; sets_q <= '0;
      prof_q <= '0; rate_q <= '0; chan_q <= '0;
      cnt_q <= '0; strm_q <= STREAM_VIDEO;
    end else begin
      if (accept) begin
        phase_q <= phase_d; pcount_q <= pcount_d; hlen_q <= hlen_d;
        kind_q <= kind_d; trem_q <= trem_d; nsb_q <= nsb_d; ulen_q <= ulen_d;
        sets_q <= sets_d; prof_q <= prof_d; rate_q <= rate_d; chan_q <= chan_d;
      end
      if (accept && bn != '0) begin
        cnt_q <= bn; strm_q <= bs;
      end else if (take) begin
        cnt_q <= cnt_q - BURST_CW'(1);
      end
    end
  end

  // burst payload, no reset
  always_ff @(posedge clk_i) begin
    if (accept && bn != '0) begin
      for (int i = 0; i < BURST_MAX; i++) burst_q[i] <= burst_d[i];
    end else if (take) begin
      for (int i = 0; i < BURST_MAX - 1; i++) burst_q[i] <= burst_q[i + 1];
      burst_q[BURST_MAX-1] <= 8'h00;
    end
  end

endmodule

[hdl/fda_checker.sv]
module fda_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tready_o,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o,
  input logic       m_axis_tuser_o,
  input logic       m_axis_tlast_o
);

  // input side waits while a burst is stalled
  a_stall_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |-> !s_axis_tready_o)
    else $error("input taken during output stall");

  // a burst runs on without gaps and keeps its stream
  a_burst_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o
      |=> m_axis_tvalid_o && $stable(m_axis_tuser_o))
    else $error("burst broken");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i
      |=> m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("stalled beat changed");

endmodule

bind flv_demux_annexb_adts fda_checker u_fda_checker (.*);

[test/flv_demux_annexb_adts_tb.sv]
module flv_demux_annexb_adts_tb;
  import fda_pkg::*;

  // parser phases
  typedef enum logic [4:0] {
    P_SIG, P_HLEN, P_HEXT, P_PREV, P_THDR, P_SKIP, P_VFIRST, P_VPTYPE, P_VCTIME,
    P_CFG, P_SPSNUM, P_SPSLEN, P_SPSDATA, P_PPSNUM, P_PPSLEN, P_PPSDATA,
    P_NALLEN, P_NALDATA, P_AFIRST, P_APTYPE, P_ASC0, P_ASCEXT, P_ASC1, P_RAW
  } phase_e;

  typedef struct packed {
    logic [7:0] data;
    logic       strm;
    logic       last;
  } es_beat_t;

  localparam int unsigned CYCLE_LIMIT = 400000;

  logic       clk_i;
  logic       rst_ni;
  logic       s_axis_tvalid_i;
  logic       s_axis_tready_o;
  logic [7:0] s_axis_tdata_i;
  logic       m_axis_tvalid_o;
  logic       m_axis_tready_i;
  logic [7:0] m_axis_tdata_o;
  logic       m_axis_tuser_o;
  logic       m_axis_tlast_o;

  flv_demux_annexb_adts dut (.*);

  // shadow parser state
  phase_e      ph;
  logic [31:0] cnt, hlen, ulen;
  logic [7:0]  kind;
  logic [23:0] rem;
  logic [2:0]  nsz;
  logic [4:0]  sets;
  logic [1:0]  prof;
  logic [3:0]  rate;
  logic [2:0]  chan;

  es_beat_t es_q[$];
  logic [7:0] flv_q[$];
  int errors;
  int n_beats;
  int cycles;
  int idle_pct, stall_pct;

  // beats produced by the current byte; last flag patched afterwards
  es_beat_t step_out[$];

  function automatic void put(logic [7:0] b, logic s);
    es_beat_t e;
    e.data = b; e.strm = s; e.last = 1'b0;
    step_out.push_back(e);
  endfunction

  function automatic void put_start();
    put(8'h00, STREAM_VIDEO); put(8'h00, STREAM_VIDEO);
    put(8'h00, STREAM_VIDEO); put(8'h01, STREAM_VIDEO);
  endfunction

  function automatic void put_adts();
    logic [12:0] len;
    len = 13'(32'd7 + rem);
    put(ADTS_SYNC0, STREAM_AUDIO);
    put(ADTS_SYNC1, STREAM_AUDIO);
    put({prof, rate, 1'b0, chan[2]}, STREAM_AUDIO);
    put({chan[1:0], 4'b0, len[12:11]}, STREAM_AUDIO);
    put(len[10:3], STREAM_AUDIO);
    put({len[2:0], ADTS_FULL_HI}, STREAM_AUDIO);
    put(ADTS_FULL_LO, STREAM_AUDIO);
  endfunction

  function automatic void parser_reset();
    ph = P_SIG; cnt = 0; hlen = 0; kind = 0; rem = 0; nsz = 3'd4;
    ulen = 0; sets = 0; prof = 0; rate = 0; chan = 0;
  endfunction

  function automatic void param_set_done(bit pps);
    sets = sets - 5'd1;
    ulen = 0; cnt = 0;
    if (sets == 0) ph = pps ? P_SKIP : P_PPSNUM;
    else ph = pps ? P_PPSLEN : P_SPSLEN;
  endfunction

  function automatic void param_len(logic [7:0] b, bit pps);
    ulen = {16'd0, ulen[7:0], b};
    cnt++;
    if (cnt >= 2) begin
      put_start();
      cnt = 0;
      if (ulen == 0) param_set_done(pps);
      else ph = pps ? P_PPSDATA : P_SPSDATA;
    end
  endfunction

  function automatic void tag_byte(logic [7:0] b);
    logic [4:0] aot;
    case (ph)
      P_VFIRST: ph = (b[3:0] == CODEC_AVC) ? P_VPTYPE : P_SKIP;
      P_VPTYPE: begin
        ulen = b; cnt = 0; ph = P_VCTIME;
      end
      P_VCTIME: begin
        cnt++;
        if (cnt >= 3) begin
          cnt = 0;
          if (ulen == 0) ph = P_CFG;
          else if (ulen == 1) ph = P_NALLEN;
          else ph = P_SKIP;
          ulen = 0;
        end
      end
      P_CFG: begin
        if (cnt == 4) begin
          nsz = {1'b0, b[1:0]} + 3'd1;
          ph = P_SPSNUM;
        end
        cnt++;
      end
      P_SPSNUM: begin
        sets = b[4:0]; cnt = 0; ulen = 0;
        ph = (sets == 0) ? P_PPSNUM : P_SPSLEN;
      end
      P_SPSLEN: param_len(b, 1'b0);
      P_SPSDATA: begin
        put(b, STREAM_VIDEO); ulen--;
        if (ulen == 0) param_set_done(1'b0);
      end
      P_PPSNUM: begin
        sets = b[4:0]; cnt = 0; ulen = 0;
        ph = (sets == 0) ? P_SKIP : P_PPSLEN;
      end
      P_PPSLEN: param_len(b, 1'b1);
      P_PPSDATA: begin
        put(b, STREAM_VIDEO); ulen--;
        if (ulen == 0) param_set_done(1'b1);
      end
      P_NALLEN: begin
        ulen = {ulen[23:0], b};
        cnt++;
        if (cnt >= nsz) begin
          put_start();
          cnt = 0;
          if (ulen != 0) ph = P_NALDATA;
        end
      end
      P_NALDATA: begin
        put(b, STREAM_VIDEO); ulen--;
        if (ulen == 0) begin
          ph = P_NALLEN; cnt = 0;
        end
      end
      P_AFIRST: ph = (b[7:4] == CODEC_AAC) ? P_APTYPE : P_SKIP;
      P_APTYPE: begin
        if (b == 0) ph = P_ASC0;
        else if (b == 1) begin
          put_adts(); ph = P_RAW;
        end else ph = P_SKIP;
      end
      P_ASC0: begin
        aot = b[7:3];
        if (aot >= 1 && aot <= 3) prof = 2'(aot - 5'd1);
        ulen = b[2:0];
        ph = (aot == AOT_ESCAPE) ? P_ASCEXT : P_ASC1;
      end
      P_ASCEXT: begin
        ulen = b[2:0]; ph = P_ASC1;
      end
      P_ASC1: begin
        rate = {ulen[2:0], b[7]};
        chan = b[5:3]; ulen = 0; ph = P_SKIP;
      end
      P_RAW: put(b, STREAM_AUDIO);
      default: ;
    endcase
  endfunction

  // Advance the shadow parser by one FLV byte, queue the expected ES beats.
  function automatic void demux_byte(logic [7:0] b);
    step_out.delete();
    case (ph)
      P_SIG: begin
        cnt++;
        if (cnt >= 5) begin
          cnt = 0; hlen = 0; ph = P_HLEN;
        end
      end
      P_HLEN: begin
        hlen = {hlen[23:0], b};
        cnt++;
        if (cnt >= 4) begin
          if (hlen > 9) begin
            cnt = 9; ph = P_HEXT;
          end else begin
            cnt = 0; ph = P_PREV;
          end
        end
      end
      P_HEXT: begin
        cnt++;
        if (cnt >= hlen) begin
          cnt = 0; ph = P_PREV;
        end
      end
      P_PREV: begin
        cnt++;
        if (cnt >= 4) begin
          cnt = 0; rem = 0; ph = P_THDR;
        end
      end
      P_THDR: begin
        if (cnt == 0) kind = b;
        else if (cnt <= 3) rem = {rem[15:0], b};
        cnt++;
        if (cnt >= 11) begin
          cnt = 0; ulen = 0;
          if (rem == 0) ph = P_PREV;
          else if (kind == TAG_VIDEO) ph = P_VFIRST;
          else if (kind == TAG_AUDIO) ph = P_AFIRST;
          else ph = P_SKIP;
        end
      end
      default: begin
        rem = rem - 24'd1;
        tag_byte(b);
        if (rem == 0) begin
          ph = P_PREV; cnt = 0; ulen = 0;
        end
      end
    endcase
    if (step_out.size() > 0) step_out[$].last = 1'b1;
    foreach (step_out[i]) es_q.push_back(step_out[i]);
  endfunction

  // ---------------- FLV building helpers (stimulus side) ----------------
  function automatic void push_b(logic [7:0] b);
    flv_q.push_back(b);
  endfunction

  // previous-tag-size word plus tag header; body bytes follow separately
  function automatic void tag_hdr(logic [7:0] k, logic [23:0] sz);
    for (int i = 0; i < 4; i++) push_b(8'($urandom));
    push_b(k);
    push_b(sz[23:16]); push_b(sz[15:8]); push_b(sz[7:0]);
    for (int i = 0; i < 7; i++) push_b(8'($urandom));
  endfunction

  function automatic void push_body(ref logic [7:0] body[$], input int cut);
    int sz;
    sz = body.size() + cut;
    if (sz < 0) sz = 0;
    tag_hdr(($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(8, 9)), 24'(sz));
    for (int i = 0; i < sz; i++) push_b(i < body.size() ? body[i] : 8'($urandom));
  endfunction

  function automatic void rand_tag();
    logic [7:0] body[$];
    int ns, nl, len, sel;
    sel = $urandom_range(0, 5);
    if (sel == 0) begin
      // AVC sequence header
      body = '{8'h17, 8'h00, 8'($urandom), 8'($urandom), 8'($urandom),
               8'h01, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)};
      ns = $urandom_range(0, 2);
      body.push_back({3'($urandom), 5'(ns)});
      repeat (ns) begin
        len = $urandom_range(0, 6);
        body.push_back(0); body.push_back(8'(len));
        repeat (len) body.push_back(8'($urandom));
      end
      ns = $urandom_range(0, 2);
      body.push_back({3'($urandom), 5'(ns)});
      repeat (ns) begin
        len = $urandom_range(0, 4);
        body.push_back(0); body.push_back(8'(len));
        repeat (len) body.push_back(8'($urandom));
      end
    end else if (sel == 1) begin
      // AVC NAL units, 1- to 4-byte lengths (size may differ, content random)
      body = '{8'h27, 8'h01, 8'($urandom), 8'($urandom), 8'($urandom)};
      nl = $urandom_range(1, 3);
      repeat (nl) begin
        len = $urandom_range(0, 6);
        repeat ($urandom_range(0, 3)) body.push_back(0);
        body.push_back(8'(len));
        repeat (len) body.push_back(8'($urandom));
      end
    end else if (sel == 2) begin
      body = '{8'hAF, 8'h00, 8'($urandom), 8'($urandom), 8'($urandom)};
    end else if (sel == 3) begin
      body = '{8'hAF, 8'h01};
      repeat ($urandom_range(0, 8)) body.push_back(8'($urandom));
    end else begin
      repeat ($urandom_range(0, 6)) body.push_back(8'($urandom));
    end
    push_body(body, ($urandom_range(0, 7) == 0) ? $urandom_range(0, 6) - 3 : 0);
  endfunction

  // ---------------- clock, reset, drivers ----------------
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // receiver: random stall, check each accepted beat
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (es_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected beat %h/%b/%b",
            m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o);
        end else begin
          es_beat_t e;
          e = es_q.pop_front();
          n_beats++;
          if (e.data !== m_axis_tdata_o || e.strm !== m_axis_tuser_o ||
              e.last !== m_axis_tlast_o) begin
            errors++;
            if (errors <= 10) $display("beat %0d: expected %h/%b/%b got %h/%b/%b",
              n_beats, e.data, e.strm, e.last,
              m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o);
          end
        end
      end
      m_axis_tready_i <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // one FLV byte per handshake; valid held until accepted, dropped only to idle
  task automatic send_byte(logic [7:0] b);
    while ($urandom_range(0, 99) < idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    demux_byte(b);
  endtask

  // directed file: extremes and special cases
  logic [7:0] dir_tbl[] = '{
    8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF,           // signature, not checked
    8'h00, 8'h00, 8'h00, 8'h05,                  // short header length
    8'hFF, 8'hFF, 8'hFF, 8'hFF,                  // prev size
    8'h09, 8'h00, 8'h00, 8'h00, 0, 0, 0, 0, 0, 0, 0, // empty tag
    8'h00, 8'h00, 8'h00, 8'h00,
    8'h08, 8'h00, 8'h00, 8'h05, 0, 0, 0, 0, 0, 0, 0,
    8'hAF, 8'h00, 8'hF9, 8'h07, 8'hFF,           // AOT escape ASC
    8'h00, 8'h00, 8'h00, 8'h00,
    8'h08, 8'h00, 8'h00, 8'h03, 0, 0, 0, 0, 0, 0, 0,
    8'hAF, 8'h01, 8'h5A                          // raw frame, ADTS header
  };

  initial begin
    logic [7:0] body[$];
    errors = 0; n_beats = 0;
    idle_pct = 0; stall_pct = 0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    m_axis_tready_i = 1'b1;
    parser_reset();
    @(posedge rst_ni);
    @(posedge clk_i);
    foreach (dir_tbl[i]) send_byte(dir_tbl[i]);
    // overlong NAL cut at tag end, one-byte length size
    body = '{8'h17, 8'h00, 0, 0, 0, 1, 2, 3, 4, 8'hFC, 8'hE0, 8'hE0};
    push_body(body, 0);
    body = '{8'h27, 8'h01, 0, 0, 0, 8'h00, 8'hFF, 8'hAA};
    push_body(body, 0);
    while (flv_q.size() > 0) send_byte(flv_q.pop_front());
    // random tags of the same file in four phases of input idling and output stalling
    for (int p = 0; p < 4; p++) begin
      idle_pct  = (p == 1 || p == 3) ? ((p == 3) ? 8 : 70) : 0;
      stall_pct = (p == 2 || p == 3) ? ((p == 3) ? 8 : 70) : 0;
      while (flv_q.size() < 80) rand_tag();
      while (flv_q.size() > 0) send_byte(flv_q.pop_front());
    end
    s_axis_tvalid_i <= 1'b0;
    while (es_q.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
